// ===== rtl/dhm_pkg.sv =====
// Types and constants shared by the device heartbeat monitor.
package dhm_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned LimW  = 16;
  localparam int unsigned DevW  = 3;
  localparam int unsigned MaskW = 6;
  localparam int unsigned DispW = 3;
  localparam int unsigned CfgAddrW = 3;

  // Item kinds carried in tuser
  typedef enum logic [0:0] {
    CMD_BEAT = 1'b0,
    CMD_SCAN = 1'b1
  } dhm_cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_REMOTE_OFF = 3'd0,
    REG_REMOTE_ON  = 3'd1,
    REG_BUS_OFF    = 3'd2,
    REG_BUS_ON     = 3'd3,
    REG_MOTOR_OFF  = 3'd4,
    REG_MOTOR_ON   = 3'd5,
    REG_ENABLE     = 3'd6
  } dhm_reg_e;

  localparam logic [LimW-1:0]  RemoteOffRst = 16'd800;
  localparam logic [LimW-1:0]  RemoteOnRst  = 16'd100;
  localparam logic [LimW-1:0]  BusOffRst    = 16'd30;
  localparam logic [LimW-1:0]  BusOnRst     = 16'd40;
  localparam logic [LimW-1:0]  MotorOffRst  = 16'd10;
  localparam logic [LimW-1:0]  MotorOnRst   = 16'd10;
  localparam logic [MaskW-1:0] EnableRst    = 6'h3f;

  // Per-device watchdog state
  typedef struct packed {
    logic [TimeW-1:0] newest;
    logic [TimeW-1:0] previous;
    logic [TimeW-1:0] online;
    logic             lost;
    logic             err;
    logic             data_err;
  } dhm_chan_t;

  // Per-device item outcome
  typedef struct packed {
    logic             timed_out;
    logic [TimeW-1:0] period;
  } dhm_res_t;

endpackage

// ===== rtl/dhm_chan.sv =====
// Next-state logic of one watched device for one heartbeat or scan item.
module dhm_chan (
  input  dhm_pkg::dhm_chan_t           state_i,
  input  logic                         beat_hit_i,
  input  logic                         scan_i,
  input  logic                         enable_i,
  input  logic [dhm_pkg::TimeW-1:0]    now_i,
  input  logic [dhm_pkg::LimW-1:0]     offline_i,
  input  logic [dhm_pkg::LimW-1:0]     online_i,
  output dhm_pkg::dhm_chan_t           state_o,
  output dhm_pkg::dhm_res_t            res_o
);
  import dhm_pkg::*;

  logic [TimeW-1:0] since_beat;
  logic [TimeW-1:0] since_online;
  logic             silent;
  logic             settling;

  assign since_beat   = now_i - state_i.newest;
  assign since_online = now_i - state_i.online;
  assign silent       = since_beat > TimeW'(offline_i);
  assign settling     = since_online < TimeW'(online_i);

  always_comb begin
    state_o       = state_i;
    res_o.timed_out = 1'b0;
    res_o.period  = '0;
    if (beat_hit_i) begin
      state_o.previous = state_i.newest;
      state_o.newest   = now_i;
      state_o.data_err = 1'b0;
      res_o.period     = since_beat;
      if (state_i.lost) begin
        state_o.lost   = 1'b0;
        state_o.online = now_i;
      end
    end else if (scan_i && enable_i) begin
      if (silent) begin
        res_o.timed_out = 1'b1;
        // a device already in error keeps its flags as they are
        if (!state_i.err) begin
          state_o.lost = 1'b1;
          state_o.err  = 1'b1;
        end
      end else if (settling) begin
        state_o.lost = 1'b0;
        state_o.err  = 1'b1;
      end else begin
        state_o.lost = 1'b0;
        state_o.err  = state_i.data_err;
      end
    end
  end

endmodule

// ===== rtl/device_heartbeat_monitor.sv =====
// Multi-device heartbeat watchdog with stream input and output.
// Each accepted item passes through the input register and then the output register, which holds its result.
// Throughput: one item per cycle while the output is not stalled; every device lane
// is evaluated in parallel between the input register and the result register.
// Reset: all beat times zero, every device lost and in error, config at defaults.
module device_heartbeat_monitor #(
  parameter int unsigned DEVICES = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [dhm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [dhm_pkg::LimW-1:0]      cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // device[2:0], time_now[34:3], zero pad
  input  logic [0:0]                    s_axis_tuser,  // command[0]
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // lost_mask[5:0], error_mask[11:6], any_lost[12], display_device[15:13],
  // remote_lost[16], period[48:17], zero pad
  output logic [55:0]                   m_axis_tdata
);
  import dhm_pkg::*;

  localparam int unsigned IdxW = $clog2(DEVICES + 1);

  // configuration
  logic [LimW-1:0]  remote_off_q, remote_on_q, bus_off_q, bus_on_q;
  logic [LimW-1:0]  motor_off_q, motor_on_q;
  logic [MaskW-1:0] enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_off_q <= RemoteOffRst;
      remote_on_q  <= RemoteOnRst;
      bus_off_q    <= BusOffRst;
      bus_on_q     <= BusOnRst;
      motor_off_q  <= MotorOffRst;
      motor_on_q   <= MotorOnRst;
      enable_q     <= EnableRst;
    end else if (cfg_we_i) begin
      case (dhm_reg_e'(cfg_addr_i))
        REG_REMOTE_OFF: remote_off_q <= cfg_wdata_i;
        REG_REMOTE_ON:  remote_on_q  <= cfg_wdata_i;
        REG_BUS_OFF:    bus_off_q    <= cfg_wdata_i;
        REG_BUS_ON:     bus_on_q     <= cfg_wdata_i;
        REG_MOTOR_OFF:  motor_off_q  <= cfg_wdata_i;
        REG_MOTOR_ON:   motor_on_q   <= cfg_wdata_i;
        REG_ENABLE:     enable_q     <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  dhm_cmd_e         cmd_q;
  logic [DevW-1:0]  dev_q;
  logic [TimeW-1:0] now_q;
  logic             advance;
  logic             out_valid_q;
  logic [55:0]      out_data_q;
  logic [55:0]      out_data_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= dhm_cmd_e'(s_axis_tuser[0]);
      dev_q <= s_axis_tdata[DevW-1:0];
      now_q <= s_axis_tdata[DevW +: TimeW];
    end
  end

  // device lanes
  dhm_chan_t        chan_q [DEVICES];
  dhm_chan_t        chan_d [DEVICES];
  dhm_res_t         res    [DEVICES];

  for (genvar g = 0; g < DEVICES; g++) begin : g_lane
    logic            enable;
    logic [LimW-1:0] off_lim;
    logic [LimW-1:0] on_lim;
    logic            hit;

    if (g < MaskW) begin : g_mask
      assign enable = enable_q[g];
    end else begin : g_always
      assign enable = 1'b1;
    end

    if (g == 0) begin : g_remote
      assign off_lim = remote_off_q;
      assign on_lim  = remote_on_q;
    end else if (g == 1) begin : g_bus
      assign off_lim = bus_off_q;
      assign on_lim  = bus_on_q;
    end else begin : g_motor
      assign off_lim = motor_off_q;
      assign on_lim  = motor_on_q;
    end

    assign hit = (cmd_q == CMD_BEAT) && (32'(dev_q) == g);

    dhm_chan u_chan (
      .state_i    (chan_q[g]),
      .beat_hit_i (hit),
      .scan_i     (cmd_q == CMD_SCAN),
      .enable_i   (enable),
      .now_i      (now_q),
      .offline_i  (off_lim),
      .online_i   (on_lim),
      .state_o    (chan_d[g]),
      .res_o      (res[g])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        chan_q[g] <= '{newest: '0, previous: '0, online: '0,
                       lost: 1'b1, err: 1'b1, data_err: 1'b1};
      end else if (advance) begin
        chan_q[g] <= chan_d[g];
      end
    end
  end

  // result assembly
  logic [MaskW-1:0] lost_mask, err_mask;
  logic             any_lost;
  logic [IdxW-1:0]  disp;
  logic [TimeW-1:0] period;

  always_comb begin
    lost_mask = '0;
    err_mask  = '0;
    any_lost  = 1'b0;
    disp      = IdxW'(DEVICES);
    period    = '0;
    // devices 0 and 1 outrank the motors and sit lowest, so the lowest
    // timed-out index is the one to display
    for (int i = DEVICES - 1; i >= 0; i--) begin
      if (res[i].timed_out) begin
        disp     = IdxW'(i);
        any_lost = 1'b1;
      end
      period = period | res[i].period;
    end
    for (int i = 0; i < DEVICES && i < MaskW; i++) begin
      lost_mask[i] = chan_d[i].lost;
      err_mask[i]  = chan_d[i].err;
    end
    out_data_d = {7'd0, period, chan_d[0].lost, DispW'(disp), any_lost, err_mask, lost_mask};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
